// File: sv/u8vt_pkg.sv
// ============================================================================
// u8vt_pkg
// Shared types and constants for the UTF-8 VT escape tokenizer.
// ============================================================================
`default_nettype none

package u8vt_pkg;

    // Parameter store size and the index and count widths that follow from it.
    localparam int MAX_PARAMS = 16;
    localparam int IDX_W      = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CNT_W      = $clog2(MAX_PARAMS + 1);

    typedef logic [20:0] cp_t;
    typedef logic [15:0] pval_t;

    // One parameter store entry.
    typedef struct packed {
        logic  given;
        pval_t value;
    } pentry_t;

    // Decoded code point event from the UTF-8 stage.
    typedef struct packed {
        logic valid;
        cp_t  cp;
    } cp_evt_t;

    // One result token.
    typedef struct packed {
        logic [2:0] kind;
        cp_t        cp;
        pval_t      value;
        logic       given;
        logic [3:0] index;
        logic [4:0] count;
        logic       priv;
        logic       drop;
        logic       last;
    } token_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_PROC,
        SEQ_READ,
        SEQ_EMIT
    } seq_state_t;

    typedef enum logic [1:0] {
        PS_GROUND,
        PS_ESC,
        PS_CSI,
        PS_OSC
    } parse_state_t;

    // Token kinds.
    localparam logic [2:0] TK_PRINT     = 3'd0;
    localparam logic [2:0] TK_CONTROL   = 3'd1;
    localparam logic [2:0] TK_ESC_FINAL = 3'd2;
    localparam logic [2:0] TK_CSI_PARAM = 3'd3;
    localparam logic [2:0] TK_OSC_CHAR  = 3'd4;
    localparam logic [2:0] TK_OSC_END   = 3'd5;

    // Character codes.
    localparam cp_t CP_BEL      = 21'h00007;
    localparam cp_t CP_ESC      = 21'h0001B;
    localparam cp_t CP_SPACE    = 21'h00020;
    localparam cp_t CP_DEL      = 21'h0007F;
    localparam cp_t CP_LBRACK   = 21'h0005B;
    localparam cp_t CP_RBRACK   = 21'h0005D;
    localparam cp_t CP_DIGIT0   = 21'h00030;
    localparam cp_t CP_DIGIT9   = 21'h00039;
    localparam cp_t CP_SEMI     = 21'h0003B;
    localparam cp_t CP_LT       = 21'h0003C;
    localparam cp_t CP_EQ       = 21'h0003D;
    localparam cp_t CP_GT       = 21'h0003E;
    localparam cp_t CP_QUEST    = 21'h0003F;
    localparam cp_t CP_FINAL_LO = 21'h00040;
    localparam cp_t CP_FINAL_HI = 21'h0007E;
    localparam cp_t CP_REPL     = 21'h0FFFD;

endpackage

`default_nettype wire

// File: sv/u8vt_byte_if.sv
// ============================================================================
// u8vt_byte_if
// Valid/ready channel that carries one raw stream byte per transfer.
// ============================================================================
`default_nettype none

interface u8vt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// File: sv/u8vt_token_if.sv
// ============================================================================
// u8vt_token_if
// Valid/ready channel that carries one tokenizer result per transfer.
// ============================================================================
`default_nettype none

interface u8vt_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [20:0] code_point;
    logic [15:0] param_value;
    logic        param_given;
    logic [3:0]  param_index;
    logic [4:0]  param_count;
    logic        private_mark;
    logic        params_dropped;
    logic        last;

    modport source (
        output valid, output token_kind, output code_point, output param_value,
        output param_given, output param_index, output param_count,
        output private_mark, output params_dropped, output last,
        input  ready
    );
    modport sink (
        input  valid, input token_kind, input code_point, input param_value,
        input  param_given, input param_index, input param_count,
        input  private_mark, input params_dropped, input last,
        output ready
    );
endinterface

`default_nettype wire

// File: sv/u8vt_utf8_dec.sv
// ============================================================================
// u8vt_utf8_dec
// UTF-8 decoder: holds the partial character and turns bytes into code points.
// ============================================================================
`default_nettype none

module u8vt_utf8_dec (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        data_byte,
    input  wire logic              commit,
    output u8vt_pkg::cp_evt_t      evt
);
    import u8vt_pkg::*;

    logic [1:0] left_reg;
    logic [1:0] left_next;
    cp_t        accum_reg;
    cp_t        accum_next;
    logic       is_cont;

    // Decode the current byte against the partial character.
    always_comb
    begin
        left_next  = left_reg;
        accum_next = accum_reg;
        evt        = '0;
        is_cont    = (data_byte[7:6] == 2'b10);
        if ((left_reg != 2'd0) && is_cont)
        begin
            accum_next = {accum_reg[14:0], data_byte[5:0]};
            left_next  = left_reg - 2'd1;
            if (left_reg == 2'd1)
            begin
                evt.valid = 1'b1;
                evt.cp    = accum_next;
            end
        end
        else
        begin
            // Any interrupted character is dropped; the byte starts afresh.
            left_next = 2'd0;
            if (!data_byte[7])
            begin
                evt.valid = 1'b1;
                evt.cp    = 21'(data_byte);
            end
            else if (data_byte[7:5] == 3'b110)
            begin
                accum_next = 21'(data_byte[4:0]);
                left_next  = 2'd1;
            end
            else if (data_byte[7:4] == 4'b1110)
            begin
                accum_next = 21'(data_byte[3:0]);
                left_next  = 2'd2;
            end
            else if (data_byte[7:3] == 5'b11110)
            begin
                accum_next = 21'(data_byte[2:0]);
                left_next  = 2'd3;
            end
            else
            begin
                evt.valid = 1'b1;
                evt.cp    = CP_REPL;
            end
        end
    end

    // Partial character state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= 2'd0;
            accum_reg <= '0;
        end
        else if (commit)
        begin
            left_reg  <= left_next;
            accum_reg <= accum_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/u8vt_param_acc.sv
// ============================================================================
// u8vt_param_acc
// Decimal accumulate unit: value times ten plus one digit, saturated.
// ============================================================================
`default_nettype none

module u8vt_param_acc (
    input  wire u8vt_pkg::pval_t   cur,
    input  wire logic [3:0]        digit,
    output u8vt_pkg::pval_t        sum
);
    import u8vt_pkg::*;

    logic [19:0] wide;

    // The product stays below 2^20, so one compare decides saturation.
    always_comb
    begin
        wide = (20'(cur) * 20'd10) + 20'(digit);
        sum  = (wide > 20'h0FFFF) ? 16'hFFFF : wide[15:0];
    end

endmodule

`default_nettype wire

// File: sv/u8vt_param_store.sv
// ============================================================================
// u8vt_param_store
// CSI parameter store: one write port and one registered read port.
// ============================================================================
`default_nettype none

module u8vt_param_store (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [u8vt_pkg::IDX_W-1:0]    waddr,
    input  wire u8vt_pkg::pentry_t             wdata,
    input  wire logic [u8vt_pkg::IDX_W-1:0]    raddr,
    output u8vt_pkg::pentry_t                  rdata
);
    import u8vt_pkg::*;

    pentry_t mem [MAX_PARAMS];
    pentry_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/utf8_vt_escape_tokenizer_top.sv
// ============================================================================
// utf8_vt_escape_tokenizer_top
// UTF-8 decoder and VT/ANSI escape tokenizer with a CSI parameter store.
// ============================================================================
//
//  Channel | Role   | Payload
//  --------+--------+-------------------------------------------------------
//  bytes   | sink   | in_byte
//  tokens  | source | token_kind, code_point, param_*, private_mark,
//          |        | params_dropped, last
//
//  A byte is taken in by the transfer, then decoded and parsed in SEQ_PROC.
//  A CSI final byte with N stored parameters then goes through a store read
//  (SEQ_READ) and N emit steps (SEQ_EMIT), paced by the store's single read port.
//  The result register lets the next byte transfer while a result waits; a
//  stalled result sink holds the parse or emit step in place.
//  Reset clears all parser state; the parameter store is not cleared.
//
`default_nettype none

module utf8_vt_escape_tokenizer_top (
    input  wire logic      clk,
    input  wire logic      rst_n,
    u8vt_byte_if.sink      bytes,
    u8vt_token_if.source   tokens
);
    import u8vt_pkg::*;

    seq_state_t       seq_reg;
    seq_state_t       seq_next;
    parse_state_t     ps_reg;
    parse_state_t     ps_cand;
    logic [7:0]       byte_reg;
    pval_t            cur_reg;
    pval_t            cur_cand;
    logic             given_reg;
    logic             given_cand;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_cand;
    logic             priv_reg;
    logic             priv_cand;
    logic             ovf_reg;
    logic             ovf_cand;
    logic [6:0]       final_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    token_t           tok_reg;
    token_t           tok_next;

    cp_evt_t          evt;
    cp_t              cp;
    pval_t            acc_sum;
    logic             out_free;
    logic             commit;
    logic             res_valid;
    token_t           res;
    logic             emit_go;
    logic             push_req;
    logic             push_fits;
    logic [CNT_W-1:0] count_push;
    logic             ovf_push;
    logic [CNT_W-1:0] count_fin;
    logic             ovf_fin;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    pentry_t          rd_data;
    logic             last_param;

    assign cp       = evt.cp;
    assign out_free = !out_valid_reg || tokens.ready;
    assign commit   = (seq_reg == SEQ_PROC) && !(res_valid && !out_free);

    u8vt_utf8_dec u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (byte_reg),
        .commit    (commit),
        .evt       (evt)
    );

    u8vt_param_acc u_acc (
        .cur   (cur_reg),
        .digit (cp[3:0]),
        .sum   (acc_sum)
    );

    u8vt_param_store u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({given_reg, cur_reg}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Effect of closing the current parameter.
    always_comb
    begin
        push_fits  = (count_reg < CNT_W'(MAX_PARAMS));
        count_push = push_fits ? (count_reg + CNT_W'(1)) : count_reg;
        ovf_push   = ovf_reg | !push_fits;
    end

    // Parser: candidate state and result for the decoded code point.
    always_comb
    begin
        ps_cand    = ps_reg;
        cur_cand   = cur_reg;
        given_cand = given_reg;
        count_cand = count_reg;
        priv_cand  = priv_reg;
        ovf_cand   = ovf_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.cp     = cp;
        res.last   = 1'b1;
        emit_go    = 1'b0;
        push_req   = 1'b0;
        count_fin  = count_reg;
        ovf_fin    = ovf_reg;
        if ((seq_reg == SEQ_PROC) && evt.valid)
        begin
            case (ps_reg)
                PS_GROUND:
                begin
                    if (cp == CP_ESC)
                    begin
                        ps_cand = PS_ESC;
                    end
                    else if ((cp < CP_SPACE) || (cp == CP_DEL))
                    begin
                        res_valid = 1'b1;
                        res.kind  = TK_CONTROL;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        res.kind  = TK_PRINT;
                    end
                end
                PS_ESC:
                begin
                    if (cp == CP_LBRACK)
                    begin
                        ps_cand    = PS_CSI;
                        count_cand = '0;
                        cur_cand   = '0;
                        given_cand = 1'b0;
                        priv_cand  = 1'b0;
                        ovf_cand   = 1'b0;
                    end
                    else if (cp == CP_RBRACK)
                    begin
                        ps_cand = PS_OSC;
                    end
                    else
                    begin
                        ps_cand   = PS_GROUND;
                        res_valid = 1'b1;
                        res.kind  = TK_ESC_FINAL;
                    end
                end
                PS_CSI:
                begin
                    if ((cp >= CP_DIGIT0) && (cp <= CP_DIGIT9))
                    begin
                        cur_cand   = acc_sum;
                        given_cand = 1'b1;
                    end
                    else if (cp == CP_SEMI)
                    begin
                        push_req = 1'b1;
                    end
                    else if ((cp == CP_QUEST) || (cp == CP_LT) ||
                             (cp == CP_EQ) || (cp == CP_GT))
                    begin
                        priv_cand = 1'b1;
                    end
                    else if ((cp >= CP_FINAL_LO) && (cp <= CP_FINAL_HI))
                    begin
                        ps_cand  = PS_GROUND;
                        push_req = given_reg || (count_reg != '0);
                        if (push_req)
                        begin
                            count_fin = count_push;
                            ovf_fin   = ovf_push;
                        end
                        if (count_fin == '0)
                        begin
                            res_valid = 1'b1;
                            res.kind  = TK_CSI_PARAM;
                            res.priv  = priv_reg;
                            res.drop  = ovf_fin;
                        end
                        else
                        begin
                            emit_go = 1'b1;
                        end
                    end
                end
                PS_OSC:
                begin
                    res_valid = 1'b1;
                    if (cp == CP_BEL)
                    begin
                        ps_cand  = PS_GROUND;
                        res.kind = TK_OSC_END;
                    end
                    else if (cp == CP_ESC)
                    begin
                        ps_cand  = PS_ESC;
                        res.kind = TK_OSC_END;
                    end
                    else
                    begin
                        res.kind = TK_OSC_CHAR;
                    end
                end
                default:
                begin
                    ps_cand = PS_GROUND;
                end
            endcase
            if (push_req)
            begin
                count_cand = count_push;
                ovf_cand   = ovf_push;
                cur_cand   = '0;
                given_cand = 1'b0;
            end
        end
    end

    assign wr_en      = commit && push_req && push_fits;
    assign last_param = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Sequencer and result register control.
    always_comb
    begin
        seq_next       = seq_reg;
        idx_next       = idx_reg;
        rd_addr        = idx_reg;
        out_valid_next = out_valid_reg && !tokens.ready;
        tok_next       = tok_reg;
        case (seq_reg)
            SEQ_IDLE:
            begin
                if (bytes.valid)
                begin
                    seq_next = SEQ_PROC;
                end
            end
            SEQ_PROC:
            begin
                if (commit)
                begin
                    if (emit_go)
                    begin
                        seq_next = SEQ_READ;
                        idx_next = '0;
                    end
                    else
                    begin
                        seq_next = SEQ_IDLE;
                    end
                    if (res_valid)
                    begin
                        out_valid_next = 1'b1;
                        tok_next       = res;
                    end
                end
            end
            SEQ_READ:
            begin
                seq_next = SEQ_EMIT;
            end
            SEQ_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tok_next.kind  = TK_CSI_PARAM;
                    tok_next.cp    = 21'(final_reg);
                    tok_next.value = rd_data.value;
                    tok_next.given = rd_data.given;
                    tok_next.index = 4'(idx_reg);
                    tok_next.count = 5'(count_reg);
                    tok_next.priv  = priv_reg;
                    tok_next.drop  = ovf_reg;
                    tok_next.last  = last_param;
                    if (last_param)
                    begin
                        seq_next = SEQ_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        rd_addr  = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    // Control and parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SEQ_IDLE;
            ps_reg        <= PS_GROUND;
            cur_reg       <= '0;
            given_reg     <= 1'b0;
            count_reg     <= '0;
            priv_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                ps_reg    <= ps_cand;
                cur_reg   <= cur_cand;
                given_reg <= given_cand;
                count_reg <= count_cand;
                priv_reg  <= priv_cand;
                ovf_reg   <= ovf_cand;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (bytes.valid && bytes.ready)
        begin
            byte_reg <= bytes.in_byte;
        end
        if (commit && emit_go)
        begin
            final_reg <= cp[6:0];
        end
    end

    // Port drive.
    assign bytes.ready           = (seq_reg == SEQ_IDLE);
    assign tokens.valid          = out_valid_reg;
    assign tokens.token_kind     = tok_reg.kind;
    assign tokens.code_point     = tok_reg.cp;
    assign tokens.param_value    = tok_reg.value;
    assign tokens.param_given    = tok_reg.given;
    assign tokens.param_index    = tok_reg.index;
    assign tokens.param_count    = tok_reg.count;
    assign tokens.private_mark   = tok_reg.priv;
    assign tokens.params_dropped = tok_reg.drop;
    assign tokens.last           = tok_reg.last;

`ifndef ASSERT_OFF
    // The store never holds more entries than it has.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PARAMS))
        else $error("parameter count exceeds store size");

    // The parameter readout only starts with at least one stored entry.
    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_READ) |-> (count_reg != '0))
        else $error("parameter readout started with an empty store");

    // Transferring the last parameter ends the readout.
    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((seq_reg == SEQ_EMIT) && out_free && last_param) |=> (seq_reg == SEQ_IDLE))
        else $error("readout did not end after the last parameter");

    // A result is never overwritten before its transfer.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !tokens.ready) |=> (out_valid_reg && $stable(tok_reg)))
        else $error("pending result was overwritten");
`endif

endmodule

`default_nettype wire
